/* rtl/dnv_pkg.sv */
`default_nettype none

package dnv_pkg;

   localparam int unsigned MAX_NAME_DEFAULT  = 255;
   localparam int unsigned MAX_LABEL_DEFAULT = 63;

   localparam int unsigned QUEUE_DEPTH   = 2;
   localparam int unsigned QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_COUNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] DOT_BYTE    = 8'h2E;
   localparam logic [7:0] HYPHEN_BYTE = 8'h2D;

   typedef struct packed {
      logic present;
      logic last;
      logic is_dot;
      logic is_alnum;
      logic is_hyphen;
   } item_class_type;

   function automatic logic byte_is_alnum(input logic [7:0] c);
      byte_is_alnum = (c >= 8'h30 && c <= 8'h39) ||
                      (c >= 8'h41 && c <= 8'h5A) ||
                      (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic item_class_type classify(input logic [7:0] c,
                                               input logic       present,
                                               input logic       last);
      item_class_type cls;
      cls.present   = present;
      cls.last      = last;
      cls.is_dot    = (c == DOT_BYTE);
      cls.is_alnum  = byte_is_alnum(c);
      cls.is_hyphen = (c == HYPHEN_BYTE);
      classify = cls;
   endfunction

endpackage

`default_nettype wire

/* rtl/dnv_front.sv */
`default_nettype none

module dnv_front (
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [7:0]             req_character,
   input  wire logic                   req_char_present,
   input  wire logic                   req_last,
   output logic                        push,
   output dnv_pkg::item_class_type     push_item,
   input  wire logic                   queue_ready
);
   import dnv_pkg::*;

   // byte classification at the point of entry
   assign req_ready = queue_ready;
   assign push      = req_valid && queue_ready;
   assign push_item = classify(req_character, req_char_present, req_last);

endmodule

`default_nettype wire

/* rtl/dnv_queue.sv */
`default_nettype none

module dnv_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire dnv_pkg::item_class_type push_item,
   output logic                        push_ready,
   input  wire logic                   pop,
   output logic                        pop_valid,
   output dnv_pkg::item_class_type     pop_item
);
   import dnv_pkg::*;

   item_class_type              entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_COUNT_W-1:0]    count_ff, count_in;

   assign push_ready = (count_ff != QUEUE_COUNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];

   function automatic logic [QUEUE_PTR_W-1:0] ptr_next(input logic [QUEUE_PTR_W-1:0] p);
      if (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) begin
         ptr_next = '0;
      end else begin
         ptr_next = p + 1'b1;
      end
   endfunction

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = ptr_next(wr_ptr_ff);
      end
      if (pop) begin
         rd_ptr_in = ptr_next(rd_ptr_ff);
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      push |-> push_ready)
      else $error("queue written while full");

   a_no_underflow : assert property (@(posedge clock) disable iff (reset)
      pop |-> pop_valid)
      else $error("queue read while empty");

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_COUNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");
`endif

endmodule

`default_nettype wire

/* rtl/dnv_back.sv */
`default_nettype none

module dnv_back #(
   parameter int unsigned MAX_NAME  = dnv_pkg::MAX_NAME_DEFAULT,
   parameter int unsigned MAX_LABEL = dnv_pkg::MAX_LABEL_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    item_valid,
   input  wire dnv_pkg::item_class_type item,
   output logic                         pop,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic                         rsp_valid_res
);
   import dnv_pkg::*;

   localparam int unsigned NAME_W  = $clog2(MAX_NAME + 1);
   localparam int unsigned LABEL_W = $clog2(MAX_LABEL + 1);
   localparam logic [NAME_W-1:0]  NAME_LIMIT  = NAME_W'(MAX_NAME);
   localparam logic [LABEL_W-1:0] LABEL_LIMIT = LABEL_W'(MAX_LABEL);
   localparam logic [NAME_W-1:0]  NAME_ONE    = NAME_W'(1);

   logic [NAME_W-1:0]  name_count_ff, name_count_in;
   logic [LABEL_W-1:0] label_count_ff, label_count_in;
   logic               prev_alnum_ff, prev_alnum_in;
   logic               prev_dot_ff, prev_dot_in;
   logic               failed_ff, failed_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_res_ff, rsp_res_in;
   logic               ok;

   assign pop           = item_valid && (!item.last || !rsp_valid_ff || rsp_ready);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_valid_res = rsp_res_ff;

   always_comb begin
      name_count_in  = name_count_ff;
      label_count_in = label_count_ff;
      prev_alnum_in  = prev_alnum_ff;
      prev_dot_in    = prev_dot_ff;
      failed_in      = failed_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_res_in     = rsp_res_ff;

      if (pop && item.present) begin
         if (name_count_ff == NAME_LIMIT) begin
            failed_in = 1'b1;
         end else begin
            name_count_in = name_count_ff + 1'b1;
         end
         if (item.is_dot) begin
            // empty label, except a leading dot that may be the root name, or a label ending in a non-alnum byte
            if (label_count_ff == '0) begin
               if (name_count_ff != '0) begin
                  failed_in = 1'b1;
               end
            end else if (!prev_alnum_ff) begin
               failed_in = 1'b1;
            end
            label_count_in = '0;
            prev_dot_in    = 1'b1;
            prev_alnum_in  = 1'b0;
         end else begin
            // anything after a root dot
            if (prev_dot_ff && name_count_ff == NAME_ONE) begin
               failed_in = 1'b1;
            end
            if (label_count_ff == '0) begin
               if (!item.is_alnum) begin
                  failed_in = 1'b1;
               end
            end else if (!item.is_alnum && !item.is_hyphen) begin
               failed_in = 1'b1;
            end
            if (label_count_ff == LABEL_LIMIT) begin
               failed_in = 1'b1;
            end else begin
               label_count_in = label_count_ff + 1'b1;
            end
            prev_alnum_in = item.is_alnum;
            prev_dot_in   = 1'b0;
         end
      end

      ok = (name_count_in != '0) && !failed_in && (prev_dot_in || prev_alnum_in);

      if (pop && item.last) begin
         rsp_valid_in   = 1'b1;
         rsp_res_in     = ok;
         name_count_in  = '0;
         label_count_in = '0;
         prev_alnum_in  = 1'b0;
         prev_dot_in    = 1'b0;
         failed_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         name_count_ff  <= '0;
         label_count_ff <= '0;
         prev_alnum_ff  <= 1'b0;
         prev_dot_ff    <= 1'b0;
         failed_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         name_count_ff  <= name_count_in;
         label_count_ff <= label_count_in;
         prev_alnum_ff  <= prev_alnum_in;
         prev_dot_ff    <= prev_dot_in;
         failed_ff      <= failed_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_res_ff <= rsp_res_in;
   end

`ifndef SYNTHESIS
   a_verdict_from_last : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(pop && item.last))
      else $error("verdict without a closing item");

   a_state_cleared : assert property (@(posedge clock) disable iff (reset)
      (pop && item.last) |=> (name_count_ff == '0 && label_count_ff == '0 && !failed_ff))
      else $error("name state not cleared after verdict");

   a_count_bounds : assert property (@(posedge clock) disable iff (reset)
      name_count_ff <= NAME_LIMIT && label_count_ff <= LABEL_LIMIT)
      else $error("count beyond limit");

   a_no_pop_onto_full : assert property (@(posedge clock) disable iff (reset)
      (pop && item.last && rsp_valid_ff) |-> rsp_ready)
      else $error("verdict would overwrite a pending transaction");
`endif

endmodule

`default_nettype wire

/* rtl/domain_name_validator.sv */
// domain name check, one byte of the name per transaction
// req channel: req_character with req_char_present, req_last on the final
//   transaction of a name; req_char_present low with req_last low is ignored,
//   req_char_present low with req_last high closes the name without a byte
// rsp channel: one rsp_valid_res per name, given for the transaction with
//   req_last high; 1 when the whole name is a valid host name
// throughput: one transaction per cycle, sustained, on both channels, while rsp_ready is high
// verdict path: the closing transaction is written to a queue entry; the back
//   then reads that entry and registers the verdict in its output register
// the front classifies each byte and writes it to the queue; the back
//   updates the name and label counters and loads the output register
// rsp stall: the back keeps taking bytes of the next name and holds only
//   at a closing transaction; the queue then fills and req_ready drops
// reset: synchronous, clears the queue, the counters and rsp_valid;
//   the block is ready as soon as reset is released
`default_nettype none

module domain_name_validator #(
   parameter int unsigned MAX_NAME  = dnv_pkg::MAX_NAME_DEFAULT,
   parameter int unsigned MAX_LABEL = dnv_pkg::MAX_LABEL_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_character,
   input  wire logic       req_char_present,
   input  wire logic       req_last,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_valid_res
);
   import dnv_pkg::*;

   logic           push;
   item_class_type push_item;
   logic           queue_ready;
   logic           pop;
   logic           pop_valid;
   item_class_type pop_item;

   dnv_front u_front (
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_character    (req_character),
      .req_char_present (req_char_present),
      .req_last         (req_last),
      .push             (push),
      .push_item        (push_item),
      .queue_ready      (queue_ready)
   );

   dnv_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .push_ready (queue_ready),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item)
   );

   dnv_back #(
      .MAX_NAME  (MAX_NAME),
      .MAX_LABEL (MAX_LABEL)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .item_valid    (pop_valid),
      .item          (pop_item),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_valid_res (rsp_valid_res)
   );

endmodule

`default_nettype wire
